// File: hw/rtl/pfp_pkg.sv
// pfp_pkg: shared types and constants for the particle frame parser
// no dependencies
`default_nettype none
package pfp_pkg;
	localparam int unsigned MaxFramesDefault = 255;
	localparam int unsigned FracBitsDefault  = 8;
	localparam logic [7:0]  Hdr0       = 8'd66;
	localparam logic [7:0]  Hdr1       = 8'd77;
	localparam logic [15:0] HdrSum     = 16'd143;
	localparam logic [15:0] MinReset   = 16'd20000;
	localparam logic [8:0]  LenDefault = 9'd24;
	localparam logic [8:0]  LenExtra   = 9'd4;
	localparam logic [23:0] SumMax     = 24'hFFFFFF;

	typedef enum logic [1:0] {
		KIND_ACCUM  = 2'd0,
		KIND_OUTWIN = 2'd1,
		KIND_CKERR  = 2'd2,
		KIND_REPORT = 2'd3
	} kind_t;

	localparam logic OP_BYTE    = 1'b0;
	localparam logic OP_COLLECT = 1'b1;

	typedef struct packed {
		logic       opcode;
		logic [7:0] rx_byte;
		logic       in_reading_window;
	} in_item_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [15:0] pm1_value;
		logic [15:0] pm25_value;
		logic [15:0] pm10_value;
		logic [23:0] pm1_mean;
		logic [23:0] pm25_mean;
		logic [23:0] pm10_mean;
		logic        mean_valid;
	} out_item_t;

	// divider request and answer
	typedef struct packed {
		logic        start;
		logic [39:0] dividend;
		logic [15:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic        done;
		logic [23:0] quotient;
	} div_rsp_t;
endpackage
`default_nettype wire

// File: hw/rtl/particle_frame_parser_trimmed_mean_unit.sv
// particle_frame_parser_trimmed_mean_unit: serial frame parser with trimmed-mean report
// depends on pfp_pkg and pfp_divider
//
// Takes one sensor byte or one collect request at a time. A byte request
// is accepted, then handled in the byte state, where the result register
// loads when the frame ends; frames are parsed for the 0x42 0x4D header,
// length byte, three big-endian pm values and the 16-bit checksum. A valid
// in-window frame is folded into per-channel saturating sums, minimums,
// maximums and a frame count. A collect request reports the three means in
// unsigned Q(24-FRAC_BITS).FRAC_BITS (Q16.8 by default), truncated,
// dropping min and max when more than two frames were counted, then clears
// the accumulators. The three means go one after another through a single
// bit-serial divider of 40 steps. ready is low while a request is in work
// or while a result waits in the output register.
`default_nettype none
module particle_frame_parser_trimmed_mean_unit #(
	parameter int unsigned MAX_FRAMES = pfp_pkg::MaxFramesDefault,
	parameter int unsigned FRAC_BITS  = pfp_pkg::FracBitsDefault
) (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               in_valid,
	output logic              in_ready,
	input  pfp_pkg::in_item_t  in_data,
	output logic              out_valid,
	input  wire               out_ready,
	output pfp_pkg::out_item_t out_data
);
	import pfp_pkg::*;

	localparam int CntW = $clog2(MAX_FRAMES + 1);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_BYTE,
		ST_TRIM,
		ST_DIV,
		ST_WAIT,
		ST_OUT
	} state_t;

	state_t       state_q;
	in_item_t     req_q;
	logic [8:0]   pos_q;
	logic [8:0]   flen_q;
	logic [15:0]  rsum_q;
	logic [15:0]  esum_q;
	logic [15:0]  fval_q [3];
	logic [23:0]  vsum_q [3];
	logic [15:0]  vmin_q [3];
	logic [15:0]  vmax_q [3];
	logic [CntW-1:0] cnt_q;
	logic [1:0]   ch_q;
	logic [23:0]  tsum_q;
	logic [23:0]  mean_q [3];
	out_item_t    out_q;
	div_req_t     dreq;
	div_rsp_t     drsp;

	// byte-path next values
	logic [8:0]   p;
	logic [7:0]   v;
	logic [8:0]   fl;
	logic [15:0]  rs_n, es_n;
	logic [15:0]  fv_n [3];
	logic         hdr_bad, fend, ok, accum;
	logic [9:0]   p2, p1;

	always_comb begin
		p = pos_q;
		v = req_q.rx_byte;
		rs_n = rsum_q;
		es_n = esum_q;
		fv_n = fval_q;
		fl = flen_q;
		hdr_bad = ((p == 9'd0) && (v != Hdr0)) || ((p == 9'd1) && (v != Hdr1));
		unique case (p)
			9'd2: begin
				rs_n = {8'd0, v};
				es_n = '0;
			end
			9'd3: fl = {1'b0, v} + LenExtra;
			9'd10: fv_n[0] = {v, 8'd0};
			9'd11: fv_n[0] = {fval_q[0][15:8], v};
			9'd12: fv_n[1] = {v, 8'd0};
			9'd13: fv_n[1] = {fval_q[1][15:8], v};
			9'd14: fv_n[2] = {v, 8'd0};
			9'd15: fv_n[2] = {fval_q[2][15:8], v};
			default: ;
		endcase
		p2 = {1'b0, p} + 10'd2;
		p1 = {1'b0, p} + 10'd1;
		if (p >= 9'd4 && p2 == {1'b0, fl}) es_n = {v, 8'd0};
		if (p >= 9'd4 && p1 == {1'b0, fl}) es_n = {es_n[15:8], v};
		if (p > 9'd2 && p2 < {1'b0, fl}) rs_n = rs_n + {8'd0, v};
		fend = !hdr_bad && (p1 == {1'b0, fl});
		ok = es_n == (rs_n + HdrSum);
		accum = ok && req_q.in_reading_window && (cnt_q < CntW'(MAX_FRAMES));
	end

	// trim and divisor for the channel in work
	logic [24:0] trim;
	logic [23:0] tsum_n;
	logic [15:0] dvs;
	logic        many;
	assign many = cnt_q > CntW'(2);
	assign trim = {9'd0, vmin_q[ch_q]} + {9'd0, vmax_q[ch_q]};
	always_comb begin
		tsum_n = vsum_q[ch_q];
		if (many) tsum_n = ({1'b0, vsum_q[ch_q]} > trim) ?
			24'({1'b0, vsum_q[ch_q]} - trim) : 24'd0;
	end
	assign dvs = many ? 16'(cnt_q - CntW'(2)) : 16'(cnt_q);

	assign dreq.start    = (state_q == ST_DIV);
	assign dreq.dividend = 40'({16'd0, tsum_q} << FRAC_BITS);
	assign dreq.divisor  = dvs;

	pfp_divider u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (dreq),
		.rsp   (drsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			pos_q   <= '0;
			flen_q  <= LenDefault;
			rsum_q  <= '0;
			esum_q  <= '0;
			cnt_q   <= '0;
			ch_q    <= '0;
			for (int c = 0; c < 3; c++) begin
				fval_q[c] <= '0;
				vsum_q[c] <= '0;
				vmin_q[c] <= MinReset;
				vmax_q[c] <= '0;
			end
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						req_q   <= in_data;
						ch_q    <= '0;
						state_q <= (in_data.opcode == OP_COLLECT) ? ST_TRIM : ST_BYTE;
					end
				end
				ST_BYTE: begin
					// one byte of the frame
					state_q <= ST_IDLE;
					if (hdr_bad) begin
						pos_q <= '0;
					end else begin
						flen_q <= fl;
						if (!fend) begin
							pos_q  <= p1[8:0];
							rsum_q <= rs_n;
							esum_q <= es_n;
							fval_q <= fv_n;
						end else begin
							out_q.pm1_value  <= fv_n[0];
							out_q.pm25_value <= fv_n[1];
							out_q.pm10_value <= fv_n[2];
							out_q.pm1_mean   <= '0;
							out_q.pm25_mean  <= '0;
							out_q.pm10_mean  <= '0;
							out_q.mean_valid <= 1'b0;
							if (!ok) out_q.kind <= KIND_CKERR;
							else if (accum) out_q.kind <= KIND_ACCUM;
							else out_q.kind <= KIND_OUTWIN;
							if (accum) begin
								for (int c = 0; c < 3; c++) begin
									vsum_q[c] <= ({1'b0, vsum_q[c]} + {9'd0, fv_n[c]} > {1'b0, SumMax}) ?
										SumMax : vsum_q[c] + {8'd0, fv_n[c]};
									if (fv_n[c] < vmin_q[c]) vmin_q[c] <= fv_n[c];
									if (fv_n[c] > vmax_q[c]) vmax_q[c] <= fv_n[c];
								end
								cnt_q <= cnt_q + CntW'(1);
							end
							pos_q  <= '0;
							rsum_q <= '0;
							esum_q <= '0;
							for (int c = 0; c < 3; c++) fval_q[c] <= '0;
							state_q <= ST_OUT;
						end
					end
				end
				ST_TRIM: begin
					tsum_q <= tsum_n;
					if (cnt_q == '0) begin
						mean_q[ch_q] <= '0;
						if (ch_q == 2'd2) state_q <= ST_OUT;
						ch_q <= ch_q + 2'd1;
					end else begin
						state_q <= ST_DIV;
					end
					if (ch_q == 2'd2 && cnt_q == '0) begin
						out_q.kind       <= KIND_REPORT;
						out_q.pm1_value  <= '0;
						out_q.pm25_value <= '0;
						out_q.pm10_value <= '0;
						out_q.pm1_mean   <= '0;
						out_q.pm25_mean  <= '0;
						out_q.pm10_mean  <= '0;
						out_q.mean_valid <= 1'b0;
						for (int c = 0; c < 3; c++) begin
							vsum_q[c] <= '0;
							vmin_q[c] <= MinReset;
							vmax_q[c] <= '0;
						end
					end
				end
				ST_DIV: state_q <= ST_WAIT;
				ST_WAIT: begin
					if (drsp.done) begin
						mean_q[ch_q] <= drsp.quotient;
						ch_q <= ch_q + 2'd1;
						if (ch_q == 2'd2) begin
							out_q.kind       <= KIND_REPORT;
							out_q.pm1_value  <= '0;
							out_q.pm25_value <= '0;
							out_q.pm10_value <= '0;
							out_q.pm1_mean   <= mean_q[0];
							out_q.pm25_mean  <= mean_q[1];
							out_q.pm10_mean  <= drsp.quotient;
							out_q.mean_valid <= 1'b1;
							for (int c = 0; c < 3; c++) begin
								vsum_q[c] <= '0;
								vmin_q[c] <= MinReset;
								vmax_q[c] <= '0;
							end
							cnt_q   <= '0;
							state_q <= ST_OUT;
						end else begin
							state_q <= ST_TRIM;
						end
					end
				end
				ST_OUT: if (out_ready) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = (state_q == ST_OUT);
	assign out_data  = out_q;

	// a report only follows a collect request
	a_report_kind: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_data.kind == KIND_REPORT) |-> req_q.opcode == OP_COLLECT)
		else $error("report without collect");
	a_count_cap: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CntW'(MAX_FRAMES)) else $error("frame count past cap");
	a_cleared_after_report: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_data.kind == KIND_REPORT) |-> cnt_q == '0)
		else $error("accumulators kept after report");
	a_pos_in_frame: assert property (@(posedge clk) disable iff (!arst_n)
		{1'b0, pos_q} < {1'b0, flen_q} || pos_q == '0)
		else $error("byte position past frame length");
endmodule
`default_nettype wire

// File: hw/rtl/pfp_divider.sv
// pfp_divider: restoring divider, one quotient bit per cycle, saturating to 24 bits
// depends on pfp_pkg
`default_nettype none
module pfp_divider (
	input  wire              clk,
	input  wire              arst_n,
	input  pfp_pkg::div_req_t req,
	output pfp_pkg::div_rsp_t rsp
);
	import pfp_pkg::*;

	logic        busy_q;
	logic [5:0]  cnt_q;
	logic [39:0] quo_q;
	logic [16:0] rem_q;
	logic [15:0] dvs_q;
	logic        done_q;
	logic [16:0] trial;
	logic [17:0] diff;

	assign trial = {rem_q[15:0], quo_q[39]};
	assign diff  = {1'b0, trial} - {2'b00, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= 6'd40;
				quo_q  <= req.dividend;
				rem_q  <= '0;
				dvs_q  <= req.divisor;
			end else if (busy_q) begin
				if (!diff[17]) begin
					rem_q <= diff[16:0];
					quo_q <= {quo_q[38:0], 1'b1};
				end else begin
					rem_q <= trial;
					quo_q <= {quo_q[38:0], 1'b0};
				end
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = (|quo_q[39:24]) ? SumMax : quo_q[23:0];

	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(busy_q)) else $error("divider done without work");
	a_no_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> !done_q) else $error("divider done while busy");
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> cnt_q != 6'd0) else $error("divider count ran out");
endmodule
`default_nettype wire
